[rtl/rme_pkg.sv]
// Shared operation codes, fault codes and fixed constants of the register machine execute core.
`default_nettype none

package rme_pkg;

  localparam int unsigned PROG_DEPTH = 65536;
  localparam int unsigned NUM_REGS   = 8;

  typedef enum logic [4:0] {
    OP_READ  = 5'd0,
    OP_WRITE = 5'd1,
    OP_LOAD  = 5'd2,
    OP_STORE = 5'd3,
    OP_ADD   = 5'd4,
    OP_SUB   = 5'd5,
    OP_GET   = 5'd6,
    OP_PUT   = 5'd7,
    OP_RST   = 5'd8,
    OP_INC   = 5'd9,
    OP_DEC   = 5'd10,
    OP_SHL   = 5'd11,
    OP_SHR   = 5'd12,
    OP_JUMP  = 5'd13,
    OP_JPOS  = 5'd14,
    OP_JZERO = 5'd15,
    OP_STRK  = 5'd16,
    OP_JUMPR = 5'd17,
    OP_HALT  = 5'd18
  } op_t;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_PC   = 2'd1,
    FAULT_MEM  = 2'd2
  } fault_t;

endpackage

`default_nettype wire

[rtl/rme_item_if.sv]
// Instruction request channel of the register machine execute core.
`default_nettype none

interface rme_item_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  operation;
  logic        [2:0]  reg_index;
  logic        [15:0] jump_target;
  logic signed [63:0] read_value;

  modport source (output valid, operation, reg_index, jump_target, read_value, input ready);
  modport sink   (input valid, operation, reg_index, jump_target, read_value, output ready);
endinterface

`default_nettype wire

[rtl/rme_result_if.sv]
// Result request channel of the register machine execute core.
`default_nettype none

interface rme_result_if;
  logic               valid;
  logic               ready;
  logic        [15:0] next_pc;
  logic               output_valid;
  logic signed [63:0] output_value;
  logic               halted;
  logic        [1:0]  fault_code;

  modport source (output valid, next_pc, output_valid, output_value, halted, fault_code,
                  input ready);
  modport sink   (input valid, next_pc, output_valid, output_value, halted, fault_code,
                  output ready);
endinterface

`default_nettype wire

[rtl/register_machine_execute_core.sv]
// Top level of the register machine execute core: register file, data memory and execute stage.
`default_nettype none

// Executes one instruction of an eight-register accumulator machine per request on the item
// channel and returns one result request with the next program counter, any value emitted by
// a write, and the halt and fault status. Register 0 (the accumulator) lives in a flip-flop
// register; registers 1 to 7 live in a small synchronous memory that is read when the
// instruction is accepted, with the write of the instruction just finishing forwarded into
// that read. The data memory is a synchronous MEM_DEPTH x 64 memory. After reset the block
// runs a clearing pass that writes zero to every data memory entry, one entry a cycle, and takes
// no instruction until the pass is done; configuration writes are taken during that pass as
// always. After that, every instruction except load leaves the execute stage once the output
// register is free, so such instructions stream at one per cycle while result.ready holds. A
// load reads the data memory at its register operand address, then writes that data to the
// accumulator. A halt or unknown opcode, a next program counter at or beyond min(program_length,
// 65536), or a load or store address at or beyond MEM_DEPTH stops the machine; from then on
// every instruction returns the current line with halted set and changes nothing, until reset.
// The user must write program_length through cfg_we and cfg_wdata while idle (not enforced).
module register_machine_execute_core
  import rme_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [16:0]   cfg_wdata,
  rme_item_if.sink           item,
  rme_result_if.source       result
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  // Configuration and architectural state.
  logic [16:0] program_length;
  logic [63:0] acc;
  logic [15:0] pc;
  logic        stopped;

  // Data memory clearing sweep.
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // Execute stage.
  logic        ex_vld;
  logic        ex_phase;   // set once a load has issued its memory read
  logic [4:0]  ex_op;
  logic [2:0]  ex_ri;
  logic [15:0] ex_tgt;
  logic [63:0] ex_rv;

  // Register file (entry 0 unused, the accumulator is held in acc).
  logic [63:0]         rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_valid;
  logic [63:0]         rf_q;
  logic                rf_ok;
  logic                fwd;
  logic [63:0]         fwd_data;
  logic                rf_we;

  // Data memory.
  logic [63:0]   dm_mem [MEM_DEPTH];
  logic [63:0]   dm_rd;
  logic          dm_we;
  logic          dm_re;
  logic [AW-1:0] dm_wa;
  logic [63:0]   dm_wd;

  // Output register.
  logic        o_vld;
  logic [15:0] o_pc;
  logic        o_outv;
  logic [63:0] o_value;
  logic        o_halted;
  fault_t      o_fault;

  // Execute decode.
  logic [63:0]   opd;
  logic [16:0]   limit;
  logic [63:0]   next_w;
  logic          halt;
  logic          fault_mem;
  logic          fault_pc;
  logic          mem_oob;
  logic [AW-1:0] mem_addr;
  logic          load_issue;
  logic          store_en;
  logic          wr_en;
  logic [2:0]    wr_idx;
  logic [63:0]   wr_data;
  logic          res_outv;
  logic [63:0]   res_value;
  logic          res_halted;
  fault_t        res_fault;
  logic [15:0]   res_pc;

  logic out_free;
  logic done;
  logic accept;

  assign opd      = (ex_ri == 3'd0) ? acc : (fwd ? fwd_data : (rf_ok ? rf_q : 64'd0));
  assign limit    = (program_length < 17'(PROG_DEPTH)) ? program_length : 17'(PROG_DEPTH);
  assign mem_oob  = (opd >= 64'(MEM_DEPTH));
  assign mem_addr = opd[AW-1:0];

  always_comb begin
    next_w     = {48'd0, pc} + 64'd1;
    halt       = 1'b0;
    fault_mem  = 1'b0;
    load_issue = 1'b0;
    store_en   = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = ex_ri;
    wr_data    = 64'd0;
    res_outv   = 1'b0;
    res_value  = 64'd0;
    if (stopped) begin
      halt = 1'b1;
    end else if (ex_phase) begin
      // Data phase of a load: the memory data goes to the accumulator.
      wr_en   = 1'b1;
      wr_idx  = 3'd0;
      wr_data = dm_rd;
    end else begin
      case (op_t'(ex_op))
        OP_READ: begin
          wr_en   = 1'b1;
          wr_idx  = 3'd0;
          wr_data = ex_rv;
        end
        OP_WRITE: begin
          res_outv  = 1'b1;
          res_value = acc;
        end
        OP_LOAD: begin
          if (mem_oob) begin
            fault_mem = 1'b1;
          end else begin
            load_issue = 1'b1;
          end
        end
        OP_STORE: begin
          if (mem_oob) begin
            fault_mem = 1'b1;
          end else begin
            store_en = 1'b1;
          end
        end
        OP_ADD: begin
          wr_en   = 1'b1;
          wr_idx  = 3'd0;
          wr_data = acc + opd;
        end
        OP_SUB: begin
          wr_en   = 1'b1;
          wr_idx  = 3'd0;
          wr_data = ($signed(acc) >= $signed(opd)) ? acc - opd : 64'd0;
        end
        OP_GET: begin
          wr_en   = 1'b1;
          wr_idx  = 3'd0;
          wr_data = opd;
        end
        OP_PUT: begin
          wr_en   = 1'b1;
          wr_data = acc;
        end
        OP_RST: begin
          wr_en   = 1'b1;
          wr_data = 64'd0;
        end
        OP_INC: begin
          wr_en   = 1'b1;
          wr_data = opd + 64'd1;
        end
        OP_DEC: begin
          wr_en   = ($signed(opd) > 64'sd0);
          wr_data = opd - 64'd1;
        end
        OP_SHL: begin
          wr_en   = 1'b1;
          wr_data = {opd[62:0], 1'b0};
        end
        OP_SHR: begin
          wr_en   = 1'b1;
          wr_data = {opd[63], opd[63:1]};
        end
        OP_JUMP: begin
          next_w = {48'd0, ex_tgt};
        end
        OP_JPOS: begin
          if ($signed(acc) > 64'sd0) begin
            next_w = {48'd0, ex_tgt};
          end
        end
        OP_JZERO: begin
          if (acc == 64'd0) begin
            next_w = {48'd0, ex_tgt};
          end
        end
        OP_STRK: begin
          wr_en   = 1'b1;
          wr_data = {48'd0, pc};
        end
        OP_JUMPR: begin
          next_w = opd;
        end
        default: begin
          halt = 1'b1;
        end
      endcase
    end

    fault_pc = !halt && !fault_mem && (next_w >= {47'd0, limit});

    if (fault_mem) begin
      res_fault = FAULT_MEM;
    end else if (fault_pc) begin
      res_fault = FAULT_PC;
    end else begin
      res_fault = FAULT_NONE;
    end
    res_halted = halt || fault_mem || fault_pc;
    res_pc     = res_halted ? pc : next_w[15:0];
  end

  assign out_free   = !o_vld || result.ready;
  assign done       = ex_vld && (ex_phase || !load_issue) && out_free;
  assign item.ready = !clearing && (!ex_vld || done);
  assign accept     = item.valid && item.ready;

  assign rf_we = done && wr_en && (wr_idx != 3'd0);
  assign dm_re = ex_vld && !ex_phase && load_issue;
  assign dm_we = clearing || (done && store_en);
  assign dm_wa = clearing ? clr_addr : mem_addr;
  assign dm_wd = clearing ? 64'd0 : acc;

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= 17'h10000;
      acc            <= 64'd0;
      pc             <= 16'd0;
      stopped        <= 1'b0;
      clearing       <= 1'b1;
      clr_addr       <= '0;
      ex_vld         <= 1'b0;
      ex_phase       <= 1'b0;
      rf_valid       <= '0;
      o_vld          <= 1'b0;
    end else begin
      if (cfg_we) begin
        program_length <= cfg_wdata;
      end

      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(MEM_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end

      if (accept) begin
        ex_vld   <= 1'b1;
        ex_phase <= 1'b0;
      end else if (done) begin
        ex_vld   <= 1'b0;
        ex_phase <= 1'b0;
      end else if (dm_re) begin
        ex_phase <= 1'b1;
      end

      if (done) begin
        if (wr_en && wr_idx == 3'd0) begin
          acc <= wr_data;
        end
        if (rf_we) begin
          rf_valid[wr_idx] <= 1'b1;
        end
        if (res_halted) begin
          stopped <= 1'b1;
        end else begin
          pc <= next_w[15:0];
        end
        o_vld <= 1'b1;
      end else if (result.ready) begin
        o_vld <= 1'b0;
      end
    end
  end

  // Payload registers of the execute stage, the read forwarding and the output.
  always_ff @(posedge clk) begin
    if (accept) begin
      ex_op    <= item.operation;
      ex_ri    <= item.reg_index;
      ex_tgt   <= item.jump_target;
      ex_rv    <= item.read_value;
      fwd      <= rf_we && (wr_idx == item.reg_index);
      fwd_data <= wr_data;
      rf_ok    <= rf_valid[item.reg_index];
    end
    if (done) begin
      o_pc     <= res_pc;
      o_outv   <= res_outv;
      o_value  <= res_value;
      o_halted <= res_halted;
      o_fault  <= res_fault;
    end
  end

  // Register file memory.
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[wr_idx] <= wr_data;
    end
    if (accept) begin
      rf_q <= rf_mem[item.reg_index];
    end
  end

  // Data memory.
  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm_mem[dm_wa] <= dm_wd;
    end
    if (dm_re) begin
      dm_rd <= dm_mem[mem_addr];
    end
  end

  assign result.valid        = o_vld;
  assign result.next_pc      = o_pc;
  assign result.output_valid = o_outv;
  assign result.output_value = o_value;
  assign result.halted       = o_halted;
  assign result.fault_code   = o_fault;

  // Once stopped, the machine stays stopped until reset.
  assert property (@(posedge clk) disable iff (rst) stopped |=> stopped)
    else $error("stopped flag cleared without reset");

  // The load data phase is only entered right after a data memory read.
  assert property (@(posedge clk) disable iff (rst) $rose(ex_phase) |-> $past(dm_re))
    else $error("load data phase without a memory read");

  // Nothing executes or is reported while the data memory is being cleared.
  assert property (@(posedge clk) disable iff (rst) clearing |-> !ex_vld && !o_vld)
    else $error("instruction in flight during the clearing pass");

  // Every faulting result also reports the machine as halted.
  assert property (@(posedge clk) disable iff (rst)
                   o_vld && o_fault != FAULT_NONE |-> o_halted)
    else $error("fault reported without halt");

endmodule

`default_nettype wire
